// ===== src/pwb_pkg.sv =====
package pwb_pkg;

   // field widths
   localparam int CMD_W    = 2;
   localparam int ADDR_W   = 20;
   localparam int DATA_W   = 48;
   localparam int COORD_W  = 12;
   localparam int PIX_W    = 8;
   localparam int WIDTH_W  = 12;
   localparam int HEIGHT_W = 11;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD_PIXEL = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_COEF  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE    = 2'd2;

   // register indexes
   localparam logic CSR_SRC_WIDTH  = 1'b0;
   localparam logic CSR_SRC_HEIGHT = 1'b1;

   localparam logic [WIDTH_W-1:0]  RESET_SRC_WIDTH  = 12'd1164;
   localparam logic [HEIGHT_W-1:0] RESET_SRC_HEIGHT = 11'd874;

   // coefficient store
   localparam int NUM_COEF   = 9;
   localparam int COEF_IDX_W = 4;

   // projection arithmetic
   localparam int PROD_W      = 61;
   localparam int SUM_W       = 62;
   localparam int MAG_W       = 61;
   localparam int FRAC_BITS   = 5;
   localparam int HUGE_SHIFT  = 30;
   localparam int QUO_W       = HUGE_SHIFT + FRAC_BITS + 1;
   localparam int PMAG_W      = 41;
   localparam int PROJ_W      = 42;
   localparam int DIV_LAT     = QUO_W + 2;
   localparam logic [PMAG_W-1:0] HUGE_MAG = {1'b1, 40'b0};

   // sampling arithmetic
   localparam int SAT_W       = 16;
   localparam int WEIGHT_BITS = 15;
   localparam int IDX_W       = 24;
   localparam int ACC_W       = 24;
   localparam logic signed [SAT_W-1:0] SAT_LOW  = -16'sd32768;
   localparam logic signed [SAT_W-1:0] SAT_HIGH = 16'sd32767;
   localparam logic [WEIGHT_BITS-1:0]  WEIGHT_MAX = 15'd32767;

   typedef enum logic [1:0] {
      KIND_PIXEL,
      KIND_COEF,
      KIND_COMPUTE
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   address;
      logic [DATA_W-1:0]   data;
      logic [COORD_W-1:0]  dest_x;
      logic [COORD_W-1:0]  dest_y;
   } item_type;

   typedef struct packed {
      logic                valid;
      kind_type            kind;
      logic [ADDR_W-1:0]   address;
      logic [PIX_W-1:0]    pix_data;
      logic [COORD_W-1:0]  dest_x;
      logic [COORD_W-1:0]  dest_y;
   } tag_type;

   typedef struct packed {
      tag_type                    tag;
      logic signed [SAT_W-1:0]    sx;
      logic signed [SAT_W-1:0]    sy;
      logic [FRAC_BITS-1:0]       ax;
      logic [FRAC_BITS-1:0]       ay;
   } sample_type;

endpackage

// ===== src/pwb_front.sv =====
module pwb_front #(
   parameter int SOURCE_DEPTH = 1048576
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pwb_pkg::CMD_W-1:0]      req_cmd,
   input  logic [pwb_pkg::ADDR_W-1:0]     req_address,
   input  logic [pwb_pkg::DATA_W-1:0]     req_data,
   input  logic [pwb_pkg::COORD_W-1:0]    req_dest_x,
   input  logic [pwb_pkg::COORD_W-1:0]    req_dest_y,
   output logic                           head_valid,
   output pwb_pkg::item_type              head_item
);

   pwb_pkg::item_type  item_ff [0:1];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               keep;
   pwb_pkg::kind_type  kind;
   logic               push, pop;

   // classify the item; drop loads out of range and unknown commands
   always_comb begin
      keep = 1'b0;
      kind = pwb_pkg::KIND_COMPUTE;
      case (req_cmd)
         pwb_pkg::CMD_LOAD_PIXEL: begin
            kind = pwb_pkg::KIND_PIXEL;
            keep = 32'(req_address) < 32'(SOURCE_DEPTH);
         end
         pwb_pkg::CMD_LOAD_COEF: begin
            kind = pwb_pkg::KIND_COEF;
            keep = req_address < pwb_pkg::ADDR_W'(pwb_pkg::NUM_COEF);
         end
         pwb_pkg::CMD_COMPUTE: begin
            kind = pwb_pkg::KIND_COMPUTE;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign busy       = count_ff == 2'd2;
   assign push       = start && !busy && keep;
   assign pop        = count_ff != 2'd0;
   assign head_valid = pop;
   assign head_item  = item_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   // advance queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the item
   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= '{kind: kind, address: req_address, data: req_data,
                                 dest_x: req_dest_x, dest_y: req_dest_y};
      end
   end

endmodule

// ===== src/pwb_div.sv =====
module pwb_div (
   input  logic                         clock,
   input  logic [pwb_pkg::MAG_W-1:0]    num,
   input  logic [pwb_pkg::MAG_W-1:0]    den,
   output logic [pwb_pkg::PMAG_W-1:0]   quot
);

   localparam int MW = pwb_pkg::MAG_W;
   localparam int QW = pwb_pkg::QUO_W;
   localparam int HS = pwb_pkg::HUGE_SHIFT;

   logic            ovf_ff [0:QW];
   logic [MW-1:0]   rem_ff [0:QW];
   logic [QW-1:0]   low_ff [0:QW];
   logic [QW-1:0]   quo_ff [0:QW];
   logic [MW-1:0]   den_ff [0:QW];
   logic [pwb_pkg::PMAG_W-1:0] quot_ff;
   logic            up;

   // flag a huge quotient and load the top dividend bits
   always_ff @(posedge clock) begin
      ovf_ff[0] <= {HS'(0), num} >= {den, HS'(0)};
      rem_ff[0] <= MW'(num[MW-1:HS]);
      low_ff[0] <= {num[HS-1:0], (pwb_pkg::FRAC_BITS + 1)'(0)};
      quo_ff[0] <= '0;
      den_ff[0] <= den;
   end

   // one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [MW:0] trial;
      logic [MW:0] diff;
      logic        fits;
      assign trial = {rem_ff[k], low_ff[k][QW-1]};
      assign diff  = trial - {1'b0, den_ff[k]};
      assign fits  = trial >= {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         ovf_ff[k+1] <= ovf_ff[k];
         rem_ff[k+1] <= fits ? diff[MW-1:0] : trial[MW-1:0];
         low_ff[k+1] <= {low_ff[k][QW-2:0], 1'b0};
         quo_ff[k+1] <= {quo_ff[k][QW-2:0], fits};
         den_ff[k+1] <= den_ff[k];
      end
   end

   // round to nearest, ties to even
   assign up = quo_ff[QW][0] & ((rem_ff[QW] != '0) | quo_ff[QW][1]);

   always_ff @(posedge clock) begin
      quot_ff <= ovf_ff[QW] ? pwb_pkg::HUGE_MAG
                 : pwb_pkg::PMAG_W'(quo_ff[QW][QW-1:1]) + pwb_pkg::PMAG_W'(up);
   end

   assign quot = quot_ff;

endmodule

// ===== src/pwb_proj.sv =====
module pwb_proj (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  pwb_pkg::item_type    in_item,
   output pwb_pkg::sample_type  samp
);

   typedef struct packed {
      pwb_pkg::tag_type tag;
      logic             neg_x;
      logic             neg_y;
      logic             w_zero;
   } line_type;

   logic signed [pwb_pkg::DATA_W-1:0] coef_ff [0:pwb_pkg::NUM_COEF-1];
   logic signed [pwb_pkg::PROD_W-1:0] prod_ff [0:5];
   logic signed [pwb_pkg::DATA_W-1:0] bias_ff [0:2];
   logic signed [pwb_pkg::SUM_W-1:0]  sum_ff  [0:2];
   pwb_pkg::tag_type   tag0_ff, tag1_ff, tag0_in;
   line_type           line2_ff, line2_in;
   line_type           line_ff [0:pwb_pkg::DIV_LAT-1];
   logic [pwb_pkg::MAG_W-1:0]  num_x_ff, num_y_ff, den_ff;
   logic [pwb_pkg::PMAG_W-1:0] quot_x, quot_y;
   logic signed [pwb_pkg::SUM_W-1:0] sum_x, sum_y, sum_w;
   logic signed [pwb_pkg::SAT_W-1:0] sx_in, sy_in;
   logic [pwb_pkg::FRAC_BITS-1:0]    ax_in, ay_in;
   pwb_pkg::sample_type samp_ff;
   logic signed [12:0] xs, ys;

   assign xs = $signed({1'b0, in_item.dest_x});
   assign ys = $signed({1'b0, in_item.dest_y});

   assign tag0_in = '{valid: in_valid && (in_item.kind != pwb_pkg::KIND_COEF),
                      kind: in_item.kind, address: in_item.address,
                      pix_data: in_item.data[pwb_pkg::PIX_W-1:0],
                      dest_x: in_item.dest_x, dest_y: in_item.dest_y};

   // write a coefficient
   always_ff @(posedge clock) begin
      if (in_valid && in_item.kind == pwb_pkg::KIND_COEF) begin
         coef_ff[in_item.address[pwb_pkg::COEF_IDX_W-1:0]] <= in_item.data;
      end
   end

   // form the six products
   always_ff @(posedge clock) begin
      prod_ff[0] <= coef_ff[0] * xs;
      prod_ff[1] <= coef_ff[1] * ys;
      prod_ff[2] <= coef_ff[3] * xs;
      prod_ff[3] <= coef_ff[4] * ys;
      prod_ff[4] <= coef_ff[6] * xs;
      prod_ff[5] <= coef_ff[7] * ys;
      bias_ff[0] <= coef_ff[2];
      bias_ff[1] <= coef_ff[5];
      bias_ff[2] <= coef_ff[8];
   end

   // sum each row of the matrix
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sum_ff[i] <= pwb_pkg::SUM_W'(prod_ff[2*i]) + pwb_pkg::SUM_W'(prod_ff[2*i+1])
                      + pwb_pkg::SUM_W'(bias_ff[i]);
      end
   end

   assign sum_x = sum_ff[0];
   assign sum_y = sum_ff[1];
   assign sum_w = sum_ff[2];

   assign line2_in = '{tag: tag1_ff,
                       neg_x: sum_x[pwb_pkg::SUM_W-1] ^ sum_w[pwb_pkg::SUM_W-1],
                       neg_y: sum_y[pwb_pkg::SUM_W-1] ^ sum_w[pwb_pkg::SUM_W-1],
                       w_zero: sum_w == '0};

   // take magnitudes for the dividers
   always_ff @(posedge clock) begin
      num_x_ff <= pwb_pkg::MAG_W'(sum_x[pwb_pkg::SUM_W-1] ? -sum_x : sum_x);
      num_y_ff <= pwb_pkg::MAG_W'(sum_y[pwb_pkg::SUM_W-1] ? -sum_y : sum_y);
      den_ff   <= pwb_pkg::MAG_W'(sum_w[pwb_pkg::SUM_W-1] ? -sum_w : sum_w);
   end

   pwb_div u_div_x (.clock(clock), .num(num_x_ff), .den(den_ff), .quot(quot_x));
   pwb_div u_div_y (.clock(clock), .num(num_y_ff), .den(den_ff), .quot(quot_y));

   // carry tags alongside the projection
   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff.valid  <= 1'b0;
         tag1_ff.valid  <= 1'b0;
         line2_ff.tag.valid <= 1'b0;
         for (int i = 0; i < pwb_pkg::DIV_LAT; i++) begin
            line_ff[i].tag.valid <= 1'b0;
         end
      end else begin
         tag0_ff  <= tag0_in;
         tag1_ff  <= tag0_ff;
         line2_ff <= line2_in;
         line_ff[0] <= line2_ff;
         for (int i = 1; i < pwb_pkg::DIV_LAT; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   // apply sign, split into saturated integer part and fraction
   function automatic logic signed [pwb_pkg::PROJ_W-1:0] signed_pos(
      input logic [pwb_pkg::PMAG_W-1:0] mag, input logic neg, input logic zero);
      logic signed [pwb_pkg::PROJ_W-1:0] v;
      v = $signed({1'b0, mag});
      if (zero) signed_pos = '0;
      else if (neg) signed_pos = -v;
      else signed_pos = v;
   endfunction

   function automatic logic signed [pwb_pkg::SAT_W-1:0] int_sat(
      input logic signed [pwb_pkg::PROJ_W-1:0] p);
      logic signed [pwb_pkg::PROJ_W-pwb_pkg::FRAC_BITS-1:0] fl;
      fl = p[pwb_pkg::PROJ_W-1:pwb_pkg::FRAC_BITS];
      if (fl < pwb_pkg::SAT_LOW) int_sat = pwb_pkg::SAT_LOW;
      else if (fl > pwb_pkg::SAT_HIGH) int_sat = pwb_pkg::SAT_HIGH;
      else int_sat = pwb_pkg::SAT_W'(fl);
   endfunction

   logic signed [pwb_pkg::PROJ_W-1:0] px, py;
   line_type last;

   assign last  = line_ff[pwb_pkg::DIV_LAT-1];
   assign px    = signed_pos(quot_x, last.neg_x, last.w_zero);
   assign py    = signed_pos(quot_y, last.neg_y, last.w_zero);
   assign sx_in = int_sat(px);
   assign sy_in = int_sat(py);
   assign ax_in = px[pwb_pkg::FRAC_BITS-1:0];
   assign ay_in = py[pwb_pkg::FRAC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         samp_ff.tag.valid <= 1'b0;
      end else begin
         samp_ff <= '{tag: last.tag, sx: sx_in, sy: sy_in, ax: ax_in, ay: ay_in};
      end
   end

   assign samp = samp_ff;

endmodule

// ===== src/pwb_sample.sv =====
module pwb_sample #(
   parameter int SOURCE_DEPTH = 1048576
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pwb_pkg::WIDTH_W-1:0]      src_width,
   input  logic [pwb_pkg::HEIGHT_W-1:0]     src_height,
   input  pwb_pkg::sample_type              samp,
   output logic                             rsp_valid,
   output logic [pwb_pkg::PIX_W-1:0]        rsp_pixel,
   output logic [pwb_pkg::COORD_W-1:0]      rsp_out_x,
   output logic [pwb_pkg::COORD_W-1:0]      rsp_out_y
);

   localparam int AW = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;
   localparam int WB = pwb_pkg::WEIGHT_BITS;
   localparam int BW = pwb_pkg::HEIGHT_W + pwb_pkg::WIDTH_W;
   localparam int PW = pwb_pkg::PIX_W + WB;

   logic [pwb_pkg::PIX_W-1:0] mem_a [0:SOURCE_DEPTH-1];
   logic [pwb_pkg::PIX_W-1:0] mem_b [0:SOURCE_DEPTH-1];

   pwb_pkg::tag_type tag0_ff, tag1_ff, tag2_ff, tag3_ff;
   logic [BW-1:0]    base_ff [0:1];
   logic [pwb_pkg::WIDTH_W-1:0] col_ff [0:1];
   logic [1:0]       col_ok_ff, row_ok_ff;
   logic [WB-1:0]    wt0_ff [0:3];
   logic [WB-1:0]    wt1_ff [0:3];
   logic [WB-1:0]    wt2_ff [0:3];
   logic [AW-1:0]    addr_ff [0:3];
   logic [3:0]       ok1_ff, ok2_ff;
   logic [pwb_pkg::PIX_W-1:0] rd_ff [0:3];
   logic [PW-1:0]    prod_ff [0:3];
   logic             rsp_valid_ff;
   logic [pwb_pkg::PIX_W-1:0]   rsp_pixel_ff;
   logic [pwb_pkg::COORD_W-1:0] rsp_out_x_ff, rsp_out_y_ff;

   logic signed [pwb_pkg::SAT_W:0] col0, col1, row0, row1;
   logic [1:0]  col_ok, row_ok;
   logic [5:0]  ix, iy;
   logic [11:0] m0, m1, m2, m3;
   logic [WB-1:0] wt [0:3];
   logic [pwb_pkg::IDX_W-1:0] idx [0:3];
   logic [pwb_pkg::ACC_W-1:0] acc;
   logic [pwb_pkg::ACC_W-WB-1:0] rounded;

   // neighbour rows and columns and their bounds
   assign col0 = {samp.sx[pwb_pkg::SAT_W-1], samp.sx};
   assign col1 = col0 + 17'sd1;
   assign row0 = {samp.sy[pwb_pkg::SAT_W-1], samp.sy};
   assign row1 = row0 + 17'sd1;
   assign col_ok[0] = !col0[pwb_pkg::SAT_W] && (col0 < 17'(src_width));
   assign col_ok[1] = !col1[pwb_pkg::SAT_W] && (col1 < 17'(src_width));
   assign row_ok[0] = !row0[pwb_pkg::SAT_W] && (row0 < 17'(src_height));
   assign row_ok[1] = !row1[pwb_pkg::SAT_W] && (row1 < 17'(src_height));

   // bilinear weights; the full weight saturates
   assign ix = 6'd32 - {1'b0, samp.ax};
   assign iy = 6'd32 - {1'b0, samp.ay};
   assign m0 = ix * iy;
   assign m1 = {6'b0, samp.ax} * iy;
   assign m2 = ix * {6'b0, samp.ay};
   assign m3 = {6'b0, samp.ax} * {6'b0, samp.ay};
   assign wt[0] = m0[10] ? pwb_pkg::WEIGHT_MAX : {m0[9:0], 5'b0};
   assign wt[1] = {m1[9:0], 5'b0};
   assign wt[2] = {m2[9:0], 5'b0};
   assign wt[3] = {m3[9:0], 5'b0};

   always_ff @(posedge clock) begin
      base_ff[0] <= row0[pwb_pkg::HEIGHT_W-1:0] * src_width;
      base_ff[1] <= row1[pwb_pkg::HEIGHT_W-1:0] * src_width;
      col_ff[0]  <= col0[pwb_pkg::WIDTH_W-1:0];
      col_ff[1]  <= col1[pwb_pkg::WIDTH_W-1:0];
      col_ok_ff  <= col_ok;
      row_ok_ff  <= row_ok;
      for (int k = 0; k < 4; k++) wt0_ff[k] <= wt[k];
   end

   // form linear indexes
   for (genvar k = 0; k < 4; k++) begin : g_idx
      assign idx[k] = pwb_pkg::IDX_W'(base_ff[k/2]) + pwb_pkg::IDX_W'(col_ff[k%2]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         addr_ff[k] <= AW'(idx[k]);
         ok1_ff[k]  <= row_ok_ff[k/2] && col_ok_ff[k%2]
                       && (32'(idx[k]) < 32'(SOURCE_DEPTH));
         wt1_ff[k]  <= wt0_ff[k];
      end
   end

   // source plane: two copies, each with two read ports
   always_ff @(posedge clock) begin
      if (tag1_ff.valid && tag1_ff.kind == pwb_pkg::KIND_PIXEL) begin
         mem_a[AW'(tag1_ff.address)] <= tag1_ff.pix_data;
         mem_b[AW'(tag1_ff.address)] <= tag1_ff.pix_data;
      end
      rd_ff[0] <= mem_a[addr_ff[0]];
      rd_ff[1] <= mem_a[addr_ff[1]];
      rd_ff[2] <= mem_b[addr_ff[2]];
      rd_ff[3] <= mem_b[addr_ff[3]];
   end

   always_ff @(posedge clock) begin
      ok2_ff <= ok1_ff;
      for (int k = 0; k < 4; k++) wt2_ff[k] <= wt1_ff[k];
   end

   // weight each neighbour; outside ones read as zero
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         prod_ff[k] <= (ok2_ff[k] ? rd_ff[k] : pwb_pkg::PIX_W'(0)) * wt2_ff[k];
      end
   end

   // blend, round and clamp
   assign acc = pwb_pkg::ACC_W'(prod_ff[0]) + pwb_pkg::ACC_W'(prod_ff[1])
              + pwb_pkg::ACC_W'(prod_ff[2]) + pwb_pkg::ACC_W'(prod_ff[3])
              + pwb_pkg::ACC_W'(1 << (WB - 1));
   assign rounded = acc[pwb_pkg::ACC_W-1:WB];

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= (rounded > 9'd255) ? 8'd255 : rounded[pwb_pkg::PIX_W-1:0];
      rsp_out_x_ff <= tag3_ff.dest_x;
      rsp_out_y_ff <= tag3_ff.dest_y;
   end

   // advance tags
   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff.valid <= 1'b0;
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tag0_ff <= samp.tag;
         tag1_ff <= tag0_ff;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         rsp_valid_ff <= tag3_ff.valid && tag3_ff.kind == pwb_pkg::KIND_COMPUTE;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;
   assign rsp_out_x = rsp_out_x_ff;
   assign rsp_out_y = rsp_out_y_ff;

endmodule

// ===== src/perspective_warp_bilinear.sv =====
// Throughput: one item per cycle; the two 38-stage dividers and the four-port
// source plane (two memories, two read ports each) are fully pipelined.
// Reset (synchronous, active high) clears the queue and all stage valid bits
// and restores the size registers; the stores stay undefined until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
module perspective_warp_bilinear #(
   parameter int SOURCE_DEPTH = 1048576
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [pwb_pkg::CMD_W-1:0]        req_cmd,
   input  logic [pwb_pkg::ADDR_W-1:0]       req_address,
   input  logic [pwb_pkg::DATA_W-1:0]       req_data,
   input  logic [pwb_pkg::COORD_W-1:0]      req_dest_x,
   input  logic [pwb_pkg::COORD_W-1:0]      req_dest_y,
   output logic                             rsp_valid,
   output logic [pwb_pkg::PIX_W-1:0]        rsp_pixel,
   output logic [pwb_pkg::COORD_W-1:0]      rsp_out_x,
   output logic [pwb_pkg::COORD_W-1:0]      rsp_out_y,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [pwb_pkg::WIDTH_W-1:0]      csr_wdata
);

   localparam int LATENCY = 48;

   logic [pwb_pkg::WIDTH_W-1:0]  width_ff;
   logic [pwb_pkg::HEIGHT_W-1:0] height_ff;
   logic                         head_valid;
   pwb_pkg::item_type            head_item;
   pwb_pkg::sample_type          samp;

   // hold the size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pwb_pkg::RESET_SRC_WIDTH;
         height_ff <= pwb_pkg::RESET_SRC_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            pwb_pkg::CSR_SRC_WIDTH:  width_ff  <= csr_wdata;
            pwb_pkg::CSR_SRC_HEIGHT: height_ff <= csr_wdata[pwb_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   pwb_front #(.SOURCE_DEPTH(SOURCE_DEPTH)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_address(req_address), .req_data(req_data),
      .req_dest_x(req_dest_x), .req_dest_y(req_dest_y),
      .head_valid(head_valid), .head_item(head_item)
   );

   pwb_proj u_proj (
      .clock(clock), .reset(reset), .in_valid(head_valid), .in_item(head_item),
      .samp(samp)
   );

   pwb_sample #(.SOURCE_DEPTH(SOURCE_DEPTH)) u_sample (
      .clock(clock), .reset(reset), .src_width(width_ff), .src_height(height_ff),
      .samp(samp), .rsp_valid(rsp_valid), .rsp_pixel(rsp_pixel),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y)
   );

   // a result always traces back to a compute item accepted at fixed latency
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_cmd == pwb_pkg::CMD_COMPUTE, LATENCY))
      else $error("result without a matching compute item");

   a_rsp_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_x == $past(req_dest_x, LATENCY))
                 && (rsp_out_y == $past(req_dest_y, LATENCY)))
      else $error("result coordinates do not match the item");

   // the back end never stalls, so the queue never fills
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      $past(start) |-> !busy)
      else $error("queue filled up");

endmodule

// ===== verif/perspective_warp_bilinear_tb.sv =====
`timescale 1ns / 1ps

// Expected pixel for one compute item
typedef struct {
   logic [7:0]  pixel;
   logic [11:0] out_x;
   logic [11:0] out_y;
} warp_pixel_type;

class warp_scoreboard;
   logic [7:0]  plane [int];
   longint      coef [9];
   int          width;
   int          height;
   warp_pixel_type pending [$];
   int          errors;

   function new();
      width  = pwb_pkg::RESET_SRC_WIDTH;
      height = pwb_pkg::RESET_SRC_HEIGHT;
      errors = 0;
      foreach (coef[i]) coef[i] = 0;
   endfunction

   function void set_reg(logic index, logic [11:0] value);
      if (index == pwb_pkg::CSR_SRC_WIDTH) width = value;
      else height = value[10:0];
   endfunction

   // round(32*n/d) to nearest even, with the huge-projection clamp
   function automatic longint project(longint n, longint d);
      bit [63:0] un, ud, q, r, mag;
      bit neg;
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      neg = (n < 0) != (d < 0);
      q = un / ud;
      r = un % ud;
      if (q >= 64'd1 << 30) begin
         mag = 64'd1 << 40;
      end else begin
         for (int i = 0; i < 5; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
               r = r - ud;
               q = q | 64'd1;
            end
         end
         r = r << 1;
         if (r > ud || (r == ud && q[0])) q = q + 1;
         mag = q;
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic int whole_part(longint v);
      longint f;
      f = v >>> 5;
      if (f < -32768) return -32768;
      if (f > 32767) return 32767;
      return int'(f);
   endfunction

   function automatic int unsigned neighbour(int x, int y);
      int idx;
      if (x < 0 || y < 0 || x >= width || y >= height) return 0;
      idx = y * width + x;
      if (idx >= 1048576 || !plane.exists(idx)) return 0;
      return plane[idx];
   endfunction

   // Note an accepted item; update stores or queue the expected pixel
   function void note_item(logic [1:0] cmd, logic [19:0] address, logic [47:0] data,
                           logic [11:0] dx, logic [11:0] dy);
      longint x, y, x0, y0, hw, px, py;
      int sx, sy;
      int unsigned ax, ay, w0, w1, w2, w3, val, pix;
      warp_pixel_type e;
      if (cmd == pwb_pkg::CMD_LOAD_PIXEL) begin
         plane[int'(address)] = data[7:0];
      end else if (cmd == pwb_pkg::CMD_LOAD_COEF) begin
         if (address < 9) coef[address] = longint'($signed(data));
      end else if (cmd == pwb_pkg::CMD_COMPUTE) begin
         x = dx;
         y = dy;
         x0 = coef[0] * x + coef[1] * y + coef[2];
         y0 = coef[3] * x + coef[4] * y + coef[5];
         hw = coef[6] * x + coef[7] * y + coef[8];
         px = (hw != 0) ? project(x0, hw) : 0;
         py = (hw != 0) ? project(y0, hw) : 0;
         sx = whole_part(px);
         sy = whole_part(py);
         ax = px[4:0];
         ay = py[4:0];
         w0 = (32 - ax) * (32 - ay) * 32;
         if (w0 > 32767) w0 = 32767;
         w1 = ax * (32 - ay) * 32;
         w2 = (32 - ax) * ay * 32;
         w3 = ax * ay * 32;
         val = neighbour(sx, sy) * w0 + neighbour(sx + 1, sy) * w1 +
               neighbour(sx, sy + 1) * w2 + neighbour(sx + 1, sy + 1) * w3;
         pix = (val + 16384) >> 15;
         if (pix > 255) pix = 255;
         e.pixel = pix[7:0];
         e.out_x = dx;
         e.out_y = dy;
         pending.push_back(e);
      end
   endfunction

   function void check_result(logic [7:0] pixel, logic [11:0] ox, logic [11:0] oy);
      warp_pixel_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected pixel %0d at (%0d,%0d)", $time, pixel, ox, oy);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (pixel !== e.pixel) begin
         $display("%0t: pixel expected %0d actual %0d", $time, e.pixel, pixel);
         errors++;
      end
      if (ox !== e.out_x) begin
         $display("%0t: out_x expected %0d actual %0d", $time, e.out_x, ox);
         errors++;
      end
      if (oy !== e.out_y) begin
         $display("%0t: out_y expected %0d actual %0d", $time, e.out_y, oy);
         errors++;
      end
   endfunction
endclass

module perspective_warp_bilinear_tb;

   localparam logic [pwb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [pwb_pkg::CMD_W-1:0]   req_cmd;
   logic [pwb_pkg::ADDR_W-1:0]  req_address;
   logic [pwb_pkg::DATA_W-1:0]  req_data;
   logic [pwb_pkg::COORD_W-1:0] req_dest_x;
   logic [pwb_pkg::COORD_W-1:0] req_dest_y;
   logic rsp_valid;
   logic [pwb_pkg::PIX_W-1:0]   rsp_pixel;
   logic [pwb_pkg::COORD_W-1:0] rsp_out_x;
   logic [pwb_pkg::COORD_W-1:0] rsp_out_y;
   logic csr_we;
   logic csr_index;
   logic [pwb_pkg::WIDTH_W-1:0] csr_wdata;

   warp_scoreboard sb;
   int idle_pct;
   int cycles = 0;

   perspective_warp_bilinear dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_address(req_address), .req_data(req_data),
      .req_dest_x(req_dest_x), .req_dest_y(req_dest_y),
      .rsp_valid(rsp_valid), .rsp_pixel(rsp_pixel),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Check every result strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_pixel, rsp_out_x, rsp_out_y);
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Hold one item until accepted, then idle cycle by cycle at the set rate
   task send(logic [1:0] cmd, logic [19:0] address, logic [47:0] data,
             logic [11:0] dx, logic [11:0] dy);
      req_cmd     <= cmd;
      req_address <= address;
      req_data    <= data;
      req_dest_x  <= dx;
      req_dest_y  <= dy;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_item(cmd, address, data, dx, dy);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task drain();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_reg(logic index, logic [11:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   // Resize the source and fill every in-range pixel
   task set_size(int w, int h);
      drain();
      write_reg(pwb_pkg::CSR_SRC_WIDTH, 12'(w));
      write_reg(pwb_pkg::CSR_SRC_HEIGHT, 12'(h));
      for (int i = 0; i < w * h; i++)
         send(pwb_pkg::CMD_LOAD_PIXEL, 20'(i), rand48(), 12'($urandom), 12'($urandom));
   endtask

   // Coefficient that keeps the projection mostly inside the source
   function automatic logic [47:0] sane_coef(int i);
      longint v;
      case (i)
         0, 4: v = longint'($urandom_range(32'h2000_0000, 32'hFFFF_FFFF)) +
                   ($urandom_range(1) ? 64'sd1 <<< 32 : 0);
         1, 3: v = longint'($urandom_range(0, 1 << 27)) - (1 << 26);
         2:    v = ((longint'($urandom_range(0, sb.width + 3)) - 2) <<< 32) +
                   longint'($urandom);
         5:    v = ((longint'($urandom_range(0, sb.height + 3)) - 2) <<< 32) +
                   longint'($urandom);
         6, 7: v = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
         default: v = (64'sd1 <<< 32) + longint'($urandom_range(0, 1 << 29)) - (1 << 28);
      endcase
      return v[47:0];
   endfunction

   task load_matrix(int kind);
      logic [47:0] v;
      for (int i = 0; i < 9; i++) begin
         if (kind == 0) v = sane_coef(i);
         else if (kind == 1) v = rand48();
         else v = (i >= 6) ? 48'd0 : rand48();
         send(pwb_pkg::CMD_LOAD_COEF, 20'(i), v, 12'($urandom), 12'($urandom));
      end
   endtask

   task compute_at_random();
      int xr, yr;
      xr = (2 * sb.width + 4 > 4095) ? 4095 : 2 * sb.width + 4;
      yr = (2 * sb.height + 4 > 4095) ? 4095 : 2 * sb.height + 4;
      if ($urandom_range(9) == 0)
         send(pwb_pkg::CMD_COMPUTE, 20'($urandom), rand48(), 12'($urandom),
              12'($urandom));
      else
         send(pwb_pkg::CMD_COMPUTE, 20'($urandom), rand48(),
              12'($urandom_range(0, xr)), 12'($urandom_range(0, yr)));
   endtask

   // One phase of random traffic
   task random_phase(int computes);
      int n, pick;
      n = 0;
      while (n < computes) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            load_matrix(($urandom_range(9) < 7) ? 0 : $urandom_range(1, 2));
         end else if (pick < 12) begin
            send(pwb_pkg::CMD_LOAD_COEF, 20'($urandom_range(0, 8)),
                 sane_coef($urandom_range(0, 8)), 12'($urandom), 12'($urandom));
         end else if (pick < 20) begin
            send(pwb_pkg::CMD_LOAD_PIXEL,
                 20'($urandom_range(0, sb.width * sb.height - 1)), rand48(),
                 12'($urandom), 12'($urandom));
         end else if (pick < 24) begin
            // ignored items: unused command, coefficient index past the end
            if ($urandom_range(1))
               send(CMD_UNUSED, 20'($urandom), rand48(), 12'($urandom), 12'($urandom));
            else
               send(pwb_pkg::CMD_LOAD_COEF, 20'($urandom_range(9, 1048575)), rand48(),
                    12'($urandom), 12'($urandom));
         end else begin
            compute_at_random();
            n++;
         end
      end
   endtask

   initial begin
      int widths [6];
      int heights [6];
      int pcts [4];
      sb = new();
      widths  = '{8, 1, 96, 1, 13, 24};
      heights = '{6, 1, 1, 40, 7, 5};
      pcts    = '{0, 52, 0, 9};
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = pwb_pkg::CMD_LOAD_PIXEL;
      req_address = '0;
      req_data = '0;
      req_dest_x = '0;
      req_dest_y = '0;
      csr_we = 1'b0;
      csr_index = pwb_pkg::CSR_SRC_WIDTH;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity map, corners, fractions, zero and huge denominators
      set_size(8, 6);
      for (int i = 0; i < 9; i++)
         send(pwb_pkg::CMD_LOAD_COEF, 20'(i),
              (i == 0 || i == 4 || i == 8) ? 48'h1_0000_0000 : 48'd0, 12'd0, 12'd0);
      send(pwb_pkg::CMD_COMPUTE, 20'd0, 48'd0, 12'd0, 12'd0);
      send(pwb_pkg::CMD_COMPUTE, 20'hFFFFF, '1, 12'd7, 12'd5);
      send(pwb_pkg::CMD_COMPUTE, 20'd0, 48'd0, 12'd4095, 12'd4095);
      send(pwb_pkg::CMD_LOAD_COEF, 20'd2, 48'h0_8800_0000, 12'd0, 12'd0);
      send(pwb_pkg::CMD_LOAD_COEF, 20'd5, 48'hFFFF_F880_0000, 12'd0, 12'd0);
      send(pwb_pkg::CMD_COMPUTE, 20'd0, 48'd0, 12'd3, 12'd2);
      send(pwb_pkg::CMD_COMPUTE, 20'd0, 48'd0, 12'd0, 12'd0);
      send(pwb_pkg::CMD_LOAD_COEF, 20'd8, 48'd0, 12'd0, 12'd0);
      send(pwb_pkg::CMD_COMPUTE, 20'd0, 48'd0, 12'd0, 12'd0);
      send(pwb_pkg::CMD_LOAD_COEF, 20'd8, 48'd1, 12'd0, 12'd0);
      send(pwb_pkg::CMD_LOAD_COEF, 20'd0, 48'h7FFF_FFFF_FFFF, 12'd0, 12'd0);
      send(pwb_pkg::CMD_LOAD_COEF, 20'd4, 48'h8000_0000_0000, 12'd0, 12'd0);
      send(pwb_pkg::CMD_COMPUTE, 20'd0, 48'd0, 12'd4095, 12'd4095);
      send(pwb_pkg::CMD_LOAD_COEF, 20'd9, 48'h1_0000_0000, 12'd0, 12'd0);
      send(pwb_pkg::CMD_LOAD_COEF, 20'hFFFFF, '1, 12'd0, 12'd0);
      send(CMD_UNUSED, 20'hFFFFF, '1, 12'd4095, 12'd4095);
      send(pwb_pkg::CMD_COMPUTE, 20'd0, 48'd0, 12'd1, 12'd1);

      // Random phases over several sizes and idle rates
      for (int p = 0; p < 6; p++) begin
         set_size(widths[p], heights[p]);
         idle_pct = pcts[p % 4];
         load_matrix(0);
         random_phase(60);
      end

      drain();
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== perspective_warp_bilinear.f =====
src/pwb_pkg.sv
src/pwb_front.sv
src/pwb_div.sv
src/pwb_proj.sv
src/pwb_sample.sv
src/perspective_warp_bilinear.sv
verif/perspective_warp_bilinear_tb.sv
